### rtl/tfst_pkg.sv
// ----------------------------------------------------------------------------
// tfst_pkg
// Shared types and constants for the TCP flow sequence tracker.
// ----------------------------------------------------------------------------
package tfst_pkg;

   localparam int FLOW_ENTRIES_DEF = 64;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'h06;

   typedef enum logic [1:0] {
      OP_SAVE_ISN = 2'd0,
      OP_PACKET   = 2'd1,
      OP_CHECK    = 2'd2,
      OP_GET_ISN  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_IGNORED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] data;
   } entry_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_tcp_port;
      logic [15:0] dst_tcp_port;
      logic [31:0] value;
      logic [15:0] frame_type;
      logic [7:0]  ip_proto;
      logic [15:0] ip_total_len;
      logic [3:0]  ip_hdr_words;
      logic [3:0]  tcp_hdr_words;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic        block;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

### rtl/tfst_if.sv
// ----------------------------------------------------------------------------
// tfst channel interfaces
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface tfst_req_if;
   logic                     valid;
   logic                     ready;
   tfst_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tfst_rsp_if;
   logic                     valid;
   logic                     ready;
   tfst_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/tcp_flow_sequence_tracker_core.sv
// ----------------------------------------------------------------------------
// tcp_flow_sequence_tracker_core
// ISN and outgoing-sequence flow tables keyed by the TCP four-tuple.
// ----------------------------------------------------------------------------
//  channel   | direction | beat contents
//  ----------+-----------+------------------------------------------------
//  req_port  | in        | opcode, four-tuple, value, packet header fields
//  rsp_port  | out       | status, result_value, block
//
//  one request at a time: accept, a scan of both tables up to the larger fill count,
//  commit, then the response waits in its register
//  the scan reads one entry of each table per cycle from its memory port
//  reset empties both tables at once (fill counts cleared), no clearing pass
//  a stalled response holds the block; no request is taken until it is gone
// ----------------------------------------------------------------------------
module tcp_flow_sequence_tracker_core #(
   parameter int FLOW_ENTRIES = tfst_pkg::FLOW_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tfst_req_if.sink    req_port,
   tfst_rsp_if.source  rsp_port
);
   import tfst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tfst_dpath #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_port.data),
      .rsp   (rsp_port.data)
   );

endmodule

### rtl/tfst_ctrl.sv
// ----------------------------------------------------------------------------
// tfst_ctrl
// Sequencer: accept, table scan, commit, response.
// ----------------------------------------------------------------------------
module tfst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tfst_pkg::cmd_type  cmd,
   input  tfst_pkg::stat_type stat
);
   import tfst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_COMMIT = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/tfst_dpath.sv
// ----------------------------------------------------------------------------
// tfst_dpath
// Flow tables, sequential key scan and update logic.
// ----------------------------------------------------------------------------
module tfst_dpath #(
   parameter int FLOW_ENTRIES = tfst_pkg::FLOW_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tfst_pkg::cmd_type         cmd,
   output tfst_pkg::stat_type        stat,
   input  tfst_pkg::req_payload_type req,
   output tfst_pkg::rsp_payload_type rsp
);
   import tfst_pkg::*;

   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FLOW_ENTRIES);

   entry_type isn_mem [FLOW_ENTRIES];
   entry_type out_mem [FLOW_ENTRIES];
   entry_type isn_rd_ff, out_rd_ff;

   opcode_type      op_ff;
   key_type         key_ff;
   logic [31:0]     val_ff;
   logic [31:0]     seq_ff;
   logic            pkt_ok_ff;
   logic [CNT_W-1:0] isn_cnt_ff, out_cnt_ff, isn_cnt_in, out_cnt_in;
   logic [CNT_W-1:0] addr_ff, p_idx_ff;
   logic            p_vld_ff;
   logic            isn_hit_ff, out_hit_ff;
   logic [IDX_W-1:0] isn_idx_ff, out_idx_ff;
   logic [31:0]     isn_val_ff, out_seq_ff;
   rsp_payload_type rsp_ff, rsp_in;

   key_type          rev_key, isn_look, out_look;
   logic [CNT_W-1:0] limit;
   logic             issue;
   logic             isn_match, out_match;
   logic [6:0]       hdr_bytes;
   logic [15:0]      pay;

   logic             isn_we, out_we;
   logic [IDX_W-1:0] isn_wa, out_wa;
   entry_type        isn_wd, out_wd;
   logic             isn_free, out_free;
   logic [31:0]      os_plus;

   // payload length clamped at zero
   assign hdr_bytes = {1'b0, req.ip_hdr_words, 2'b00} + {1'b0, req.tcp_hdr_words, 2'b00};
   assign pay = (req.ip_total_len > {9'd0, hdr_bytes}) ?
                req.ip_total_len - {9'd0, hdr_bytes} : 16'd0;

   assign rev_key  = '{sip: key_ff.dip, dip: key_ff.sip,
                       sport: key_ff.dport, dport: key_ff.sport};
   assign isn_look = (op_ff == OP_CHECK) ? rev_key : key_ff;
   assign out_look = (op_ff == OP_CHECK) ? key_ff : rev_key;

   assign limit          = (isn_cnt_ff > out_cnt_ff) ? isn_cnt_ff : out_cnt_ff;
   assign stat.scan_done = (addr_ff == limit);
   assign issue          = cmd.scan && !stat.scan_done;

   assign isn_match = p_vld_ff && (p_idx_ff < isn_cnt_ff) && (isn_rd_ff.key == isn_look);
   assign out_match = p_vld_ff && (p_idx_ff < out_cnt_ff) && (out_rd_ff.key == out_look);

   always_ff @(posedge clock) begin
      if (issue) begin
         isn_rd_ff <= isn_mem[addr_ff[IDX_W-1:0]];
         out_rd_ff <= out_mem[addr_ff[IDX_W-1:0]];
      end
      if (isn_we) isn_mem[isn_wa] <= isn_wd;
      if (out_we) out_mem[out_wa] <= out_wd;
   end

   // commit: table writes and the response beat
   always_comb begin
      isn_free   = (isn_cnt_ff < CNT_MAX);
      out_free   = (out_cnt_ff < CNT_MAX);
      isn_we     = 1'b0;
      out_we     = 1'b0;
      isn_wa     = isn_hit_ff ? isn_idx_ff : isn_cnt_ff[IDX_W-1:0];
      out_wa     = out_hit_ff ? out_idx_ff : out_cnt_ff[IDX_W-1:0];
      isn_wd     = '{key: key_ff, data: val_ff};
      out_wd     = '{key: rev_key, data: 32'd0};
      isn_cnt_in = isn_cnt_ff;
      out_cnt_in = out_cnt_ff;
      rsp_in     = '{status: ST_OK, result_value: 32'd0, block: 1'b0};
      os_plus    = (out_hit_ff ? out_seq_ff : 32'd0) + 32'd1;
      if (cmd.commit) begin
         unique case (op_ff)
            OP_SAVE_ISN: begin
               if (!(out_hit_ff || out_free) || !(isn_hit_ff || isn_free)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  isn_we = 1'b1;
                  out_we = 1'b1;
                  if (!isn_hit_ff) isn_cnt_in = isn_cnt_ff + 1'b1;
                  if (!out_hit_ff) out_cnt_in = out_cnt_ff + 1'b1;
               end
            end
            OP_PACKET: begin
               out_wd.data = seq_ff;
               if (!pkt_ok_ff) begin
                  rsp_in.status = ST_IGNORED;
               end else if (out_hit_ff) begin
                  out_we = (out_seq_ff < seq_ff);
               end else if (out_free) begin
                  out_we     = 1'b1;
                  out_cnt_in = out_cnt_ff + 1'b1;
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_CHECK: begin
               if (!isn_hit_ff) rsp_in.status = ST_NOT_FOUND;
               else             rsp_in.block  = (os_plus < val_ff);
            end
            OP_GET_ISN: begin
               if (!isn_hit_ff) rsp_in.status       = ST_NOT_FOUND;
               else             rsp_in.result_value = isn_val_ff;
            end
            default: rsp_in.status = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= opcode_type'(req.opcode);
         key_ff    <= '{sip: req.src_ip, dip: req.dst_ip,
                        sport: req.src_tcp_port, dport: req.dst_tcp_port};
         val_ff    <= req.value;
         seq_ff    <= req.value + {16'd0, pay};
         pkt_ok_ff <= (req.frame_type == ETHERTYPE_IPV4) && (req.ip_proto == PROTO_TCP);
      end
      if (cmd.commit) rsp_ff <= rsp_in;
      if (isn_match) begin
         isn_idx_ff <= p_idx_ff[IDX_W-1:0];
         isn_val_ff <= isn_rd_ff.data;
      end
      if (out_match) begin
         out_idx_ff <= p_idx_ff[IDX_W-1:0];
         out_seq_ff <= out_rd_ff.data;
      end
      p_idx_ff <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_cnt_ff <= '0;
         out_cnt_ff <= '0;
         addr_ff    <= '0;
         p_vld_ff   <= 1'b0;
         isn_hit_ff <= 1'b0;
         out_hit_ff <= 1'b0;
      end else begin
         isn_cnt_ff <= isn_cnt_in;
         out_cnt_ff <= out_cnt_in;
         p_vld_ff   <= issue;
         if (cmd.capture) begin
            addr_ff    <= '0;
            isn_hit_ff <= 1'b0;
            out_hit_ff <= 1'b0;
         end else begin
            if (issue)     addr_ff    <= addr_ff + 1'b1;
            if (isn_match) isn_hit_ff <= 1'b1;
            if (out_match) out_hit_ff <= 1'b1;
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

### rtl/tfst_checker.sv
// ----------------------------------------------------------------------------
// tfst_checker
// Port-level checks on the tracker's request and response channels.
// ----------------------------------------------------------------------------
module tfst_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_block
);
   import tfst_pkg::*;

   // one request in flight: never ready while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while response pending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second beat taken");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");

   a_blk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block) |-> (rsp_status == ST_OK))
      else $error("block with bad status");

endmodule

bind tcp_flow_sequence_tracker_core tfst_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_status (rsp_port.data.status),
   .rsp_block  (rsp_port.data.block)
);
